// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion helpers, sampled on clk_i and off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, expr) \
  `ASSERT_CLK(lbl, !(expr))

`else

`define ASSERT_CLK(lbl, prop)

`define ASSERT_NEVER(lbl, expr)

`endif

`endif

// ----- rtl/core/eti_pkg.sv -----
`timescale 1ns / 1ps

package eti_pkg;

  localparam int PROG_DEPTH  = 4096;
  localparam int TAPE_DEPTH  = 32768;
  localparam int STACK_DEPTH = 256;

  localparam int PROG_AW  = $clog2(PROG_DEPTH);
  localparam int TAPE_AW  = $clog2(TAPE_DEPTH);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int LVL_W    = $clog2(STACK_DEPTH + 1);
  localparam int PC_W     = 13;
  localparam int NEST_W   = 12;

  localparam logic [NEST_W-1:0]  NEST_MAX = '1;
  localparam logic [TAPE_AW-1:0] TP_MAX   = TAPE_AW'(TAPE_DEPTH - 1);
  localparam logic [PC_W-1:0]    PROG_MAX = PC_W'(PROG_DEPTH);
  localparam logic [LVL_W-1:0]   LVL_MAX  = LVL_W'(STACK_DEPTH);

  localparam logic [7:0] CH_RIGHT = 8'h3E;  // '>'
  localparam logic [7:0] CH_LEFT  = 8'h3C;  // '<'
  localparam logic [7:0] CH_INC   = 8'h2B;  // '+'
  localparam logic [7:0] CH_DEC   = 8'h2D;  // '-'
  localparam logic [7:0] CH_OUT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_IN    = 8'h2C;  // ','
  localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_req;
  } in_word_t;

  typedef struct packed {
    logic            out_valid;
    logic [7:0]      out_byte;
    logic            took_input;
    logic            halted;
    logic            overflowed;
    logic [PC_W-1:0] step_position;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
  } dp_sts_t;

endpackage

// ----- rtl/core/eti_in_if.sv -----
`timescale 1ns / 1ps

interface eti_in_if;
  logic              valid;
  logic              ready;
  eti_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/eti_out_if.sv -----
`timescale 1ns / 1ps

interface eti_out_if;
  logic               valid;
  logic               ready;
  eti_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/eti_ctrl.sv -----
`timescale 1ns / 1ps

module eti_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  eti_pkg::dp_sts_t   sts_i,
  output eti_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free     = !out_valid_q || out_ready_i;
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.clear   = (state_q == ST_CLEAR);
  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.commit  = (state_q == ST_EXEC) && slot_free;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_o.capture) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the result register can take the new word
        if (slot_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/eti_dp.sv -----
`timescale 1ns / 1ps

module eti_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eti_pkg::ctrl_cmd_t cmd_i,
  output eti_pkg::dp_sts_t   sts_o,
  input  eti_pkg::in_word_t  in_word_i,
  output eti_pkg::out_word_t out_word_o
);

  // memories
  logic [7:0]                  prog_mem [eti_pkg::PROG_DEPTH];
  logic [7:0]                  tape_mem [eti_pkg::TAPE_DEPTH];
  logic [eti_pkg::PROG_AW-1:0] stk_mem  [eti_pkg::STACK_DEPTH];

  logic [7:0]                  prog_rd_q;
  logic [7:0]                  cell_q;
  logic [eti_pkg::PROG_AW-1:0] stk_rd_q;

  // architectural state
  logic [eti_pkg::PC_W-1:0]    len_q, len_d;
  logic [eti_pkg::PC_W-1:0]    pc_q, pc_d;
  logic [eti_pkg::TAPE_AW-1:0] tp_q, tp_d;
  logic [eti_pkg::LVL_W-1:0]   lvl_q, lvl_d;
  logic                        skip_q, skip_d;
  logic [eti_pkg::NEST_W-1:0]  nest_q, nest_d;
  logic                        ovf_q, ovf_d;

  logic [eti_pkg::TAPE_AW-1:0] clr_addr_q;
  logic                        clr_done_q;

  logic                        kind_q;
  logic [7:0]                  byte_q;
  eti_pkg::out_word_t          res_q, res_d;

  logic                        prog_we;
  logic                        tape_we;
  logic [7:0]                  tape_wd;
  logic                        stk_we;
  logic                        run_ok;
  logic [eti_pkg::LVL_W-1:0]   lvl_m1;
  logic [eti_pkg::PC_W-1:0]    pc_inc;

  assign lvl_m1 = lvl_q - eti_pkg::LVL_W'(1);
  assign pc_inc = pc_q + eti_pkg::PC_W'(1);
  assign run_ok = (kind_q == eti_pkg::KIND_STEP) && (pc_q < len_q);

  always_comb begin
    len_d   = len_q;
    pc_d    = pc_q;
    tp_d    = tp_q;
    lvl_d   = lvl_q;
    skip_d  = skip_q;
    nest_d  = nest_q;
    ovf_d   = ovf_q;
    prog_we = 1'b0;
    tape_we = 1'b0;
    tape_wd = cell_q;
    stk_we  = 1'b0;
    res_d   = '0;

    if (kind_q == eti_pkg::KIND_LOAD) begin
      if (len_q < eti_pkg::PROG_MAX) begin
        prog_we = 1'b1;
        len_d   = len_q + eti_pkg::PC_W'(1);
      end
    end else if (run_ok && skip_q) begin
      pc_d = pc_inc;
      if (prog_rd_q == eti_pkg::CH_OPEN) begin
        if (nest_q != eti_pkg::NEST_MAX) nest_d = nest_q + eti_pkg::NEST_W'(1);
      end else if (prog_rd_q == eti_pkg::CH_CLOSE) begin
        if (nest_q == '0) skip_d = 1'b0;
        else nest_d = nest_q - eti_pkg::NEST_W'(1);
      end
    end else if (run_ok) begin
      pc_d = pc_inc;
      case (prog_rd_q)
        eti_pkg::CH_RIGHT: begin
          if (tp_q != eti_pkg::TP_MAX) tp_d = tp_q + eti_pkg::TAPE_AW'(1);
        end
        eti_pkg::CH_LEFT: begin
          if (tp_q != '0) tp_d = tp_q - eti_pkg::TAPE_AW'(1);
        end
        eti_pkg::CH_INC: begin
          tape_we = 1'b1;
          tape_wd = cell_q + 8'd1;
        end
        eti_pkg::CH_DEC: begin
          tape_we = 1'b1;
          tape_wd = cell_q - 8'd1;
        end
        eti_pkg::CH_OUT: begin
          res_d.out_valid = 1'b1;
          res_d.out_byte  = cell_q;
        end
        eti_pkg::CH_IN: begin
          tape_we          = 1'b1;
          tape_wd          = byte_q;
          res_d.took_input = 1'b1;
        end
        eti_pkg::CH_OPEN: begin
          if (cell_q == 8'd0) begin
            skip_d = 1'b1;
            nest_d = '0;
          end else if (lvl_q < eti_pkg::LVL_MAX) begin
            stk_we = 1'b1;
            lvl_d  = lvl_q + eti_pkg::LVL_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        eti_pkg::CH_CLOSE: begin
          // empty stack: no effect
          if (lvl_q != '0) begin
            if (cell_q != 8'd0) pc_d = {1'b0, stk_rd_q} + eti_pkg::PC_W'(1);
            else lvl_d = lvl_m1;
          end
        end
        default: ;
      endcase
    end

    res_d.halted        = (pc_d >= len_d);
    res_d.overflowed    = ovf_d;
    res_d.step_position = pc_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && prog_we) prog_mem[len_q[eti_pkg::PROG_AW-1:0]] <= byte_q;
    prog_rd_q <= prog_mem[pc_q[eti_pkg::PROG_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      tape_mem[clr_addr_q] <= 8'd0;
    end else if (cmd_i.commit && tape_we) begin
      tape_mem[tp_q] <= tape_wd;
    end
    cell_q <= tape_mem[tp_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && stk_we) stk_mem[lvl_q[eti_pkg::STACK_AW-1:0]] <= pc_q[eti_pkg::PROG_AW-1:0];
    stk_rd_q <= stk_mem[lvl_m1[eti_pkg::STACK_AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      pc_q       <= '0;
      tp_q       <= '0;
      lvl_q      <= '0;
      skip_q     <= 1'b0;
      nest_q     <= '0;
      ovf_q      <= 1'b0;
      clr_addr_q <= '0;
      clr_done_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + eti_pkg::TAPE_AW'(1);
        if (clr_addr_q == eti_pkg::TP_MAX) clr_done_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        len_q  <= len_d;
        pc_q   <= pc_d;
        tp_q   <= tp_d;
        lvl_q  <= lvl_d;
        skip_q <= skip_d;
        nest_q <= nest_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_word_i.kind;
      byte_q <= in_word_i.byte_req;
    end
    if (cmd_i.commit) res_q <= res_d;
  end

  assign sts_o.clear_done = clr_done_q;
  assign out_word_o       = res_q;

endmodule

// ----- rtl/core/esoteric_tape_interpreter_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Eight-command tape interpreter. A word with kind 0 appends its byte to the
// program; a word with kind 1 runs the program character at the program
// counter and returns one result word. After reset the block zeroes its
// 32768-cell tape one cell per cycle, so in_i.ready stays low until the
// last cell is cleared. From then on a word is taken in the idle state, in
// which the program byte, the current tape cell and the top of the loop
// stack are read from synchronous memories; in the execute state the command
// runs and writes back, and only then is the next word taken. The result
// sits in an output register, so a stall on out_o holds the block only once
// a second result is ready behind it.
module esoteric_tape_interpreter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  eti_in_if.sink     in_i,
  eti_out_if.source  out_o
);

  eti_pkg::ctrl_cmd_t cmd;
  eti_pkg::dp_sts_t   sts;

  eti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  eti_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_word_i  (in_i.data),
    .out_word_o (out_o.data)
  );

  `ASSERT_NEVER(a_no_accept_in_clear, cmd.capture && !sts.clear_done)
  `ASSERT_CLK(a_busy_after_accept, cmd.capture |=> !in_i.ready)
  `ASSERT_CLK(a_commit_shows_word, cmd.commit |=> out_o.valid)
  `ASSERT_NEVER(a_clear_excl, cmd.clear && (cmd.capture || cmd.commit))

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  eti_in_if  in_if ();
  eti_out_if out_if ();

  esoteric_tape_interpreter_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Interpreter state as the block should hold it
  logic [7:0]                   prog_mem   [eti_pkg::PROG_DEPTH];
  logic [eti_pkg::PC_W-1:0]     prog_len   = '0;
  logic [eti_pkg::PC_W-1:0]     pc         = '0;
  logic [7:0]                   tape_mem   [eti_pkg::TAPE_DEPTH] = '{default: 8'h00};
  logic [eti_pkg::TAPE_AW-1:0]  tape_ptr   = '0;
  logic [eti_pkg::PROG_AW-1:0]  loop_stack [eti_pkg::STACK_DEPTH];
  logic [eti_pkg::LVL_W-1:0]    loop_lvl   = '0;
  logic                         skip_on    = 1'b0;
  logic [eti_pkg::NEST_W-1:0]   skip_depth = '0;
  logic                         ovf_seen   = 1'b0;

  eti_pkg::out_word_t expected_results [$];
  logic [7:0]  code_q [$];
  bit          gaps_on    = 1'b1;
  int unsigned hold_len   = 0;
  int unsigned words_sent = 0;
  int unsigned mismatches = 0;

  function automatic eti_pkg::out_word_t interpret_word(eti_pkg::in_word_t w);
    eti_pkg::out_word_t       r;
    logic [7:0]               ch;
    logic [7:0]               cur_val;
    logic [eti_pkg::PC_W-1:0] nxt;
    r = '0;
    if (w.kind == eti_pkg::KIND_LOAD) begin
      if (prog_len < eti_pkg::PROG_MAX) begin
        prog_mem[prog_len[eti_pkg::PROG_AW-1:0]] = w.byte_req;
        prog_len++;
      end
    end else if (pc < prog_len) begin
      ch = prog_mem[pc[eti_pkg::PROG_AW-1:0]];
      if (skip_on) begin
        if (ch == eti_pkg::CH_OPEN) begin
          if (skip_depth != eti_pkg::NEST_MAX) skip_depth++;
        end else if (ch == eti_pkg::CH_CLOSE) begin
          if (skip_depth == '0) skip_on = 1'b0;
          else skip_depth--;
        end
        pc++;
      end else begin
        cur_val = tape_mem[tape_ptr];
        nxt     = pc + 1'b1;
        case (ch)
          eti_pkg::CH_RIGHT: if (tape_ptr != eti_pkg::TP_MAX) tape_ptr++;
          eti_pkg::CH_LEFT:  if (tape_ptr != '0) tape_ptr--;
          eti_pkg::CH_INC:   tape_mem[tape_ptr] = cur_val + 8'd1;
          eti_pkg::CH_DEC:   tape_mem[tape_ptr] = cur_val - 8'd1;
          eti_pkg::CH_OUT: begin
            r.out_valid = 1'b1;
            r.out_byte  = cur_val;
          end
          eti_pkg::CH_IN: begin
            tape_mem[tape_ptr] = w.byte_req;
            r.took_input       = 1'b1;
          end
          eti_pkg::CH_OPEN: begin
            if (cur_val == 8'd0) begin
              skip_on    = 1'b1;
              skip_depth = '0;
            end else if (loop_lvl < eti_pkg::LVL_MAX) begin
              loop_stack[loop_lvl[eti_pkg::STACK_AW-1:0]] = pc[eti_pkg::PROG_AW-1:0];
              loop_lvl++;
            end else begin
              ovf_seen = 1'b1;
            end
          end
          eti_pkg::CH_CLOSE: begin
            if (loop_lvl != '0) begin
              if (cur_val != 8'd0) begin
                nxt = eti_pkg::PC_W'(loop_stack[eti_pkg::STACK_AW'(loop_lvl - 1'b1)])
                      + 1'b1;
              end else begin
                loop_lvl--;
              end
            end
          end
          default: ;
        endcase
        pc = nxt;
      end
    end
    r.halted        = (pc >= prog_len);
    r.overflowed    = ovf_seen;
    r.step_position = pc;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {eti_pkg::CH_RIGHT, eti_pkg::CH_LEFT, eti_pkg::CH_INC,
                     eti_pkg::CH_DEC, eti_pkg::CH_OUT, eti_pkg::CH_IN,
                     eti_pkg::CH_OPEN, eti_pkg::CH_CLOSE});
    return c;
  endfunction

  task automatic send_word(input logic kind, input logic [7:0] b);
    eti_pkg::in_word_t w;
    int unsigned       gap;
    w.kind     = kind;
    w.byte_req = b;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    expected_results.push_back(interpret_word(w));
    words_sent++;
  endtask

  task automatic load_word(input logic [7:0] b);
    send_word(eti_pkg::KIND_LOAD, b);
  endtask

  task automatic step_word(input logic [7:0] b);
    send_word(eti_pkg::KIND_STEP, b);
  endtask

  task automatic run_to_end();
    while (pc < prog_len) step_word(8'($urandom));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // Every loop body lowers the cell it tests, so each loop ends
  task automatic gen_loop(input int depth);
    code_q.push_back(eti_pkg::CH_OPEN);
    case ($urandom_range(0, 2))
      0: begin
        code_q.push_back(eti_pkg::CH_DEC);
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 2))
            0: code_q.push_back(eti_pkg::CH_OUT);
            1: code_q.push_back(noise_char());
            default: begin
              if (depth < 2) gen_loop(depth + 1);
              else code_q.push_back(eti_pkg::CH_OUT);
            end
          endcase
        end
      end
      1: begin
        code_q.push_back(eti_pkg::CH_DEC);
        code_q.push_back(eti_pkg::CH_RIGHT);
        code_q.push_back(eti_pkg::CH_INC);
        code_q.push_back(eti_pkg::CH_LEFT);
      end
      default: begin
        code_q.push_back(eti_pkg::CH_DEC);
        code_q.push_back(eti_pkg::CH_LEFT);
        code_q.push_back(eti_pkg::CH_INC);
        code_q.push_back(eti_pkg::CH_RIGHT);
      end
    endcase
    code_q.push_back(eti_pkg::CH_CLOSE);
  endtask

  task automatic gen_code(input int len);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 11))
        0, 1: repeat ($urandom_range(1, 4)) code_q.push_back(eti_pkg::CH_INC);
        2: code_q.push_back(eti_pkg::CH_DEC);
        3: code_q.push_back(eti_pkg::CH_RIGHT);
        4: code_q.push_back(eti_pkg::CH_LEFT);
        5: code_q.push_back(eti_pkg::CH_OUT);
        6: code_q.push_back(eti_pkg::CH_IN);
        7: code_q.push_back(noise_char());
        8: code_q.push_back(eti_pkg::CH_CLOSE);  // stray close, stack is empty here
        default: gen_loop(0);
      endcase
    end
  endtask

  task automatic test_directed_commands();
    step_word(8'($urandom));
    load_word(eti_pkg::CH_LEFT);
    load_word(eti_pkg::CH_IN);
    load_word(eti_pkg::CH_OUT);
    load_word(eti_pkg::CH_INC);
    load_word(eti_pkg::CH_OUT);
    load_word(eti_pkg::CH_RIGHT);
    load_word(eti_pkg::CH_IN);
    load_word(eti_pkg::CH_DEC);
    load_word(eti_pkg::CH_OUT);
    load_word(eti_pkg::CH_CLOSE);
    load_word(8'h00);
    load_word(8'hFF);
    step_word(8'($urandom));
    step_word(8'hFF);
    repeat (4) step_word(8'($urandom));
    step_word(8'h00);
    run_to_end();
    // zero cell: skip a nested loop, then a loop that jumps back once
    load_word(eti_pkg::CH_LEFT);
    load_word(eti_pkg::CH_OPEN);
    load_word(eti_pkg::CH_INC);
    load_word(eti_pkg::CH_OPEN);
    load_word(eti_pkg::CH_CLOSE);
    load_word(eti_pkg::CH_CLOSE);
    load_word(eti_pkg::CH_INC);
    load_word(eti_pkg::CH_INC);
    load_word(eti_pkg::CH_OPEN);
    load_word(eti_pkg::CH_DEC);
    load_word(eti_pkg::CH_OUT);
    load_word(eti_pkg::CH_CLOSE);
    load_word(eti_pkg::CH_OPEN);
    run_to_end();
    step_word(8'($urandom));
    // skipping resumes on the appended bytes
    load_word(eti_pkg::CH_RIGHT);
    load_word(eti_pkg::CH_CLOSE);
    load_word(eti_pkg::CH_OUT);
    run_to_end();
  endtask

  task automatic test_random_programs();
    int unsigned first;
    int unsigned snippet;
    first   = words_sent;
    snippet = 0;
    while (words_sent - first < 400 && prog_len < eti_pkg::PC_W'(2000)) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      code_q.delete();
      gen_code($urandom_range(4, 12));
      if (snippet == 0) hold_len = 300;
      if (snippet == 1) wait_drained();
      while (code_q.size() != 0) begin
        load_word(code_q.pop_front());
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) step_word(8'($urandom));
      end
      run_to_end();
      if ($urandom_range(0, 3) == 0) step_word(8'($urandom));
      snippet++;
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_stack_overflow();
    load_word(eti_pkg::CH_IN);
    repeat (eti_pkg::STACK_DEPTH + 1) load_word(eti_pkg::CH_OPEN);
    load_word(eti_pkg::CH_DEC);
    repeat (eti_pkg::STACK_DEPTH) load_word(eti_pkg::CH_CLOSE);
    step_word(8'h02);
    run_to_end();
  endtask

  task automatic test_tape_top();
    gaps_on = 1'b0;
    // sweep right in strides until the pointer pins at the top
    while (tape_ptr != eti_pkg::TP_MAX) begin
      load_word(eti_pkg::CH_IN);
      load_word(eti_pkg::CH_OPEN);
      repeat (16) load_word(eti_pkg::CH_RIGHT);
      load_word(eti_pkg::CH_INC);
      load_word(eti_pkg::CH_CLOSE);
      step_word(8'h01);
      run_to_end();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_program_full();
    while (prog_len < eti_pkg::PROG_MAX) load_word(eti_pkg::CH_OPEN);
    repeat (3) load_word(8'($urandom));
    run_to_end();
    step_word(8'($urandom));
  endtask

  task automatic check_field(input string what, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10) $display("%s: expected %0h, got %0h", what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    eti_pkg::out_word_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing pending: %h", out_if.data);
      end else begin
        want = expected_results.pop_front();
        check_field("out_valid", 16'(want.out_valid), 16'(out_if.data.out_valid));
        check_field("out_byte", 16'(want.out_byte), 16'(out_if.data.out_byte));
        check_field("took_input", 16'(want.took_input), 16'(out_if.data.took_input));
        check_field("halted", 16'(want.halted), 16'(out_if.data.halted));
        check_field("overflowed", 16'(want.overflowed), 16'(out_if.data.overflowed));
        check_field("step_position", 16'(want.step_position),
                    16'(out_if.data.step_position));
      end
    end
  end

  initial begin : result_pacer
    int unsigned stall;
    forever begin
      stall    = (hold_len != 0) ? hold_len : pick_gap();
      hold_len = 0;
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    #40_000_000;
    $display("esoteric_tape_interpreter_core: mismatch");
    $finish;
  end

  initial begin : test_sequence
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_commands();
    test_random_programs();
    test_stack_overflow();
    test_tape_top();
    test_program_full();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("esoteric_tape_interpreter_core: match");
    end else begin
      $display("esoteric_tape_interpreter_core: mismatch");
    end
    $finish;
  end

endmodule
